### sv/itoa_pkg.sv
// Shared types, codes and character helpers for the integer-to-ASCII converter.
package itoa_pkg;

    localparam int VALUE_W = 32;
    localparam int MODE_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 32;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS   = 8'd45;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'd97;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'd65;
    localparam logic [3:0]        DEC_RADIX     = 4'd10;

    typedef enum logic [MODE_W-1:0] {
        MODE_DEC  = 3'd0,
        MODE_OCT  = 3'd1,
        MODE_BIN  = 3'd2,
        MODE_HEXL = 3'd3,
        MODE_HEXU = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [MODE_W-1:0]  mode;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0]  character;
        logic               last_char;
        logic [COUNT_W-1:0] total_count;
    } t_out;

    typedef struct packed {
        logic  load;
        logic  dabble;
        logic  shift;
        t_mode mode;
    } t_sh_ctl;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] character;
        logic              last_char;
    } t_push;

    function automatic logic [CHAR_W-1:0] ascii_digit(input logic [3:0] digit,
                                                      input logic upper);
        logic [CHAR_W-1:0] base;
        if (digit < DEC_RADIX) begin
            ascii_digit = ASCII_ZERO + {4'b0000, digit};
        end else begin
            base        = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
            ascii_digit = base + {4'b0000, digit} - {4'b0000, DEC_RADIX};
        end
    endfunction

endpackage

### sv/itoa_shift.sv
// Digit shift register: loads the magnitude, runs double dabble, shifts out digits.
module itoa_shift
    import itoa_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  t_sh_ctl               i_ctl,
    input  logic [DATA_WIDTH-1:0] i_mag,
    output logic [3:0]            o_digit
);

    localparam int NDEC  = ((DATA_WIDTH * 1233) >> 12) + 1;
    localparam int BCD_W = NDEC * 4;
    localparam int OCT_W = ((DATA_WIDTH + 2) / 3) * 3;
    localparam int HEX_W = ((DATA_WIDTH + 3) / 4) * 4;
    localparam int SW    = BCD_W + DATA_WIDTH;

    logic [SW-1:0] r_sh;
    logic [SW-1:0] n_sh;
    logic [SW-1:0] w_fix;

    always_comb begin
        w_fix = r_sh;
        for (int i = 0; i < NDEC; i++) begin
            if (r_sh[SW-1-4*i -: 4] >= 4'd5) begin
                w_fix[SW-1-4*i -: 4] = r_sh[SW-1-4*i -: 4] + 4'd3;
            end
        end
    end

    always_comb begin
        n_sh = r_sh;
        priority if (i_ctl.load) begin
            n_sh = '0;
            unique case (i_ctl.mode)
                MODE_DEC: n_sh = SW'(i_mag);
                MODE_OCT: n_sh[SW-1 -: OCT_W] = OCT_W'(i_mag);
                MODE_BIN: n_sh[SW-1 -: DATA_WIDTH] = i_mag;
                MODE_HEXL, MODE_HEXU: n_sh[SW-1 -: HEX_W] = HEX_W'(i_mag);
                default: n_sh = SW'(i_mag);
            endcase
        end else if (i_ctl.dabble) begin
            n_sh = w_fix << 1;
        end else if (i_ctl.shift) begin
            unique case (i_ctl.mode)
                MODE_BIN: n_sh = r_sh << 1;
                MODE_OCT: n_sh = r_sh << 3;
                default:  n_sh = r_sh << 4;
            endcase
        end else begin
            n_sh = r_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh <= n_sh;
    end

    always_comb begin
        unique case (i_ctl.mode)
            MODE_BIN: o_digit = {3'b000, r_sh[SW-1]};
            MODE_OCT: o_digit = {1'b0, r_sh[SW-1 -: 3]};
            default:  o_digit = r_sh[SW-1 -: 4];
        endcase
    end

endmodule

### sv/itoa_ctrl.sv
// Sequencer: takes a number, steps the shift register and hands out characters.
module itoa_ctrl
    import itoa_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in                   i_data,
    input  logic [3:0]            i_digit,
    input  logic                  i_room,
    output t_sh_ctl               o_ctl,
    output logic [DATA_WIDTH-1:0] o_mag,
    output t_push                 o_push
);

    localparam int NDEC = ((DATA_WIDTH * 1233) >> 12) + 1;
    localparam int NOCT = (DATA_WIDTH + 2) / 3;
    localparam int NHEX = (DATA_WIDTH + 3) / 4;
    localparam int CW   = $clog2(DATA_WIDTH + 1);
    localparam int EW   = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    t_state          r_state;
    t_state          n_state;
    t_mode           r_mode;
    t_mode           n_mode;
    logic            r_neg;
    logic            n_neg;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;
    logic [CW-1:0]   r_bits;
    logic [CW-1:0]   n_bits;

    logic [EW-1:0]         w_ext;
    logic [DATA_WIDTH-1:0] w_val;
    t_mode                 w_mode;
    logic                  w_mode_ok;
    logic                  w_neg;
    logic [CW-1:0]         w_ndig;
    logic                  w_upper;

    assign w_ext     = EW'(i_data.value);
    assign w_val     = w_ext[DATA_WIDTH-1:0];
    assign w_mode    = t_mode'(i_data.mode);
    assign w_mode_ok = (i_data.mode <= MODE_HEXU);
    assign w_neg     = (w_mode == MODE_DEC) && w_val[DATA_WIDTH-1];
    assign o_mag     = w_neg ? (~w_val + DATA_WIDTH'(1)) : w_val;
    assign w_upper   = (r_mode == MODE_HEXU);

    always_comb begin
        unique case (w_mode)
            MODE_DEC: w_ndig = CW'(NDEC);
            MODE_OCT: w_ndig = CW'(NOCT);
            MODE_BIN: w_ndig = CW'(DATA_WIDTH);
            default:  w_ndig = CW'(NHEX);
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_neg        = r_neg;
        n_cnt        = r_cnt;
        n_bits       = r_bits;
        o_ready      = 1'b0;
        o_ctl.load   = 1'b0;
        o_ctl.dabble = 1'b0;
        o_ctl.shift  = 1'b0;
        o_ctl.mode   = r_mode;
        o_push       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && w_mode_ok) begin
                    o_ctl.load = 1'b1;
                    o_ctl.mode = w_mode;
                    n_mode     = w_mode;
                    n_neg      = w_neg;
                    n_cnt      = w_ndig;
                    n_bits     = CW'(DATA_WIDTH);
                    n_state    = (w_mode == MODE_DEC) ? ST_DABBLE : ST_SKIP;
                end
            end
            ST_DABBLE: begin
                o_ctl.dabble = 1'b1;
                n_bits       = r_bits - CW'(1);
                if (r_bits == CW'(1)) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if ((i_digit == 4'd0) && (r_cnt > CW'(1))) begin
                    o_ctl.shift = 1'b1;
                    n_cnt       = r_cnt - CW'(1);
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (i_room) begin
                    o_push.valid     = 1'b1;
                    o_push.character = ASCII_MINUS;
                    o_push.last_char = 1'b0;
                    n_state          = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_room) begin
                    o_push.valid     = 1'b1;
                    o_push.character = ascii_digit(i_digit, w_upper);
                    o_push.last_char = (r_cnt == CW'(1));
                    o_ctl.shift      = 1'b1;
                    n_cnt            = r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_mode <= n_mode;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
        r_bits <= n_bits;
    end

endmodule

### sv/itoa_out.sv
// Output register with the running character count.
module itoa_out
    import itoa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_valid,
    input  logic  i_ready,
    output t_out  o_data
);

    logic               r_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic [COUNT_W-1:0] r_count;

    assign o_room = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else if (i_push.valid) begin
            r_valid <= 1'b1;
            r_count <= r_count + COUNT_W'(1);
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_push.valid) begin
            r_char <= i_push.character;
            r_last <= i_push.last_char;
        end
    end

    assign o_valid            = r_valid;
    assign o_data.character   = r_char;
    assign o_data.last_char   = r_last;
    assign o_data.total_count = r_count;

endmodule

### sv/integer_to_ascii_radix.sv
// Integer-to-ASCII converter top level: signed decimal, octal, binary and hex output.
// Each accepted number is printed most significant digit first, one character per
// output transaction, without leading zeros; a negative decimal number is led by
// a minus sign and the most negative value prints its true magnitude. Modes 5 to 7
// are dropped without output. One number is worked on at a time. Decimal first runs
// bit-serial double dabble over all DATA_WIDTH bits, then skips leading zero digit
// slots and emits the digits, led by the minus sign when negative. Binary, octal
// and hex skip leading zero digit slots and emit the rest directly. Output stalls
// hold the sign and digit steps. The output register lets the next number be taken
// while the last character still waits downstream. total_count is the number of
// characters emitted since reset, wrapping at 32 bits.
module integer_to_ascii_radix
    import itoa_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_sh_ctl               w_ctl;
    t_push                 w_push;
    logic [DATA_WIDTH-1:0] w_mag;
    logic [3:0]            w_digit;
    logic                  w_room;

    itoa_ctrl #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_digit (w_digit),
        .i_room  (w_room),
        .o_ctl   (w_ctl),
        .o_mag   (w_mag),
        .o_push  (w_push)
    );

    itoa_shift #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_shift (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_mag   (w_mag),
        .o_digit (w_digit)
    );

    itoa_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
